/* hdl/eaad_pkg.sv */
// eaad_pkg: shared constants, stage payload types and the golden-number table
// for the easter and advent date pipeline
// depends on nothing
package eaad_pkg;

    localparam int YEAR_W   = 11;
    localparam int FULL_W   = 12;
    localparam int CENT_W   = 6;
    localparam int Q19_W    = 8;
    localparam int DAY_W    = 19;
    localparam int LEAP_W   = 10;
    localparam int SUM_W    = 13;
    localparam int GOLD_W   = 5;
    localparam int EPACT_W  = 5;
    localparam int Q7_W     = 10;
    localparam int MONTH_W  = 3;
    localparam int MDAY_W   = 5;

    localparam logic [FULL_W-1:0] YEAR_BASE = 12'd1900;

    // reciprocal constants for the constant divisions
    localparam logic [12:0] CENT_RECIP  = 13'd5243;
    localparam int          CENT_SHIFT  = 19;
    localparam logic [11:0] GOLD_RECIP  = 12'd3450;
    localparam int          GOLD_SHIFT  = 16;
    localparam logic [13:0] WEEK_RECIP  = 14'd9363;
    localparam int          WEEK_SHIFT  = 16;
    localparam logic [5:0]  THIRD_RECIP = 6'd43;
    localparam int          THIRD_SHIFT = 7;
    localparam logic [5:0]  SEVENTH_RECIP = 6'd37;
    localparam int          SEVENTH_SHIFT = 8;

    // 2^19 - 719468 mod 2^19, moves the day count to the 1970 epoch
    localparam logic [DAY_W-1:0] EPOCH_ADJ  = 19'd329108;
    localparam logic [DAY_W-1:0] ADVENT_OFS = 19'd278;
    localparam logic [6:0]       MARCH_DOY  = 7'd27;

    localparam logic [MONTH_W-1:0] MONTH_MARCH = 3'd3;
    localparam logic [MONTH_W-1:0] MONTH_APRIL = 3'd4;

    typedef struct packed {
        logic [FULL_W-1:0] year;
        logic [CENT_W-1:0] century;
        logic [Q19_W-1:0]  gold_quot;
        logic [DAY_W-1:0]  year_days;
    } prep_t;

    typedef struct packed {
        logic [EPACT_W-1:0] epact;
        logic [SUM_W-1:0]   week_sum;
        logic [Q7_W-1:0]    week_quot;
        logic [DAY_W-1:0]   base_day;
    } cyc_t;

    typedef struct packed {
        logic [MONTH_W-1:0] easter_month;
        logic [MDAY_W-1:0]  easter_day;
        logic [DAY_W-1:0]   easter_day_number;
        logic [DAY_W-1:0]   advent_day_number;
    } date_t;

    // (19 * g + 15) mod 30
    function automatic logic [EPACT_W-1:0] gold_term(input logic [GOLD_W-1:0] g);
        logic [EPACT_W-1:0] r;
        case (g)
            5'd0:    r = 5'd15;
            5'd1:    r = 5'd4;
            5'd2:    r = 5'd23;
            5'd3:    r = 5'd12;
            5'd4:    r = 5'd1;
            5'd5:    r = 5'd20;
            5'd6:    r = 5'd9;
            5'd7:    r = 5'd28;
            5'd8:    r = 5'd17;
            5'd9:    r = 5'd6;
            5'd10:   r = 5'd25;
            5'd11:   r = 5'd14;
            5'd12:   r = 5'd3;
            5'd13:   r = 5'd22;
            5'd14:   r = 5'd11;
            5'd15:   r = 5'd0;
            5'd16:   r = 5'd19;
            5'd17:   r = 5'd8;
            5'd18:   r = 5'd27;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

/* hdl/easter_and_advent_dates.sv */
// easter_and_advent_dates: gregorian easter and advent sunday for one year a request
// throughput one year per cycle while the output is not stalled, set by the five register
// stages each taking one year per clock; a stage that holds a bubble takes a new year
// even while stalled
// rst_n clears every stage valid bit at once, payload registers are not reset
// depends on eaad_pkg, eaad_prep, eaad_cycle, eaad_date
module easter_and_advent_dates
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // years_after_1900
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata    // easter_month, easter_day, easter_day_number,
                                         // advent_day_number
);

    eaad_pkg::prep_t   prep_data;
    eaad_pkg::cyc_t    cyc_data;
    eaad_pkg::date_t   date_data;
    logic              prep_valid;
    logic              prep_ready;
    logic              cyc_valid;
    logic              cyc_ready;

    eaad_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_year   (s_axis_tdata[eaad_pkg::YEAR_W-1:0]),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    eaad_cycle u_cycle
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (cyc_valid),
        .out_ready (cyc_ready),
        .out_data  (cyc_data)
    );

    eaad_date u_date
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cyc_valid),
        .in_ready  (cyc_ready),
        .in_data   (cyc_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (date_data)
    );

    assign m_axis_tdata = {2'b00,
                           date_data.advent_day_number,
                           date_data.easter_day_number,
                           date_data.easter_day,
                           date_data.easter_month};

endmodule

/* hdl/eaad_prep.sv */
// eaad_prep: first two pipeline stages, full year, century, golden-number
// quotient and 365 * year by constant multiplication
// depends on eaad_pkg
module eaad_prep
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [eaad_pkg::YEAR_W-1:0]    in_year,
    output logic                           out_valid,
    input  logic                           out_ready,
    output eaad_pkg::prep_t                out_data
);

    logic                          v1_reg;
    logic                          v2_reg;
    logic [eaad_pkg::FULL_W-1:0]   year1_reg;
    logic [eaad_pkg::FULL_W-1:0]   year1_next;
    eaad_pkg::prep_t               p2_reg;
    eaad_pkg::prep_t               p2_next;
    logic                          en1;
    logic                          en2;
    logic [24:0]                   cent_prod;
    logic [23:0]                   gold_prod;
    logic [20:0]                   days_prod;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign year1_next = {1'b0, in_year} + eaad_pkg::YEAR_BASE;

    always_comb
    begin
        cent_prod = 25'(year1_reg) * 25'(eaad_pkg::CENT_RECIP);
        gold_prod = 24'(year1_reg) * 24'(eaad_pkg::GOLD_RECIP);
        days_prod = 21'(year1_reg) * 21'd365;
        p2_next.year      = year1_reg;
        p2_next.century   = eaad_pkg::CENT_W'(cent_prod >> eaad_pkg::CENT_SHIFT);
        p2_next.gold_quot = eaad_pkg::Q19_W'(gold_prod >> eaad_pkg::GOLD_SHIFT);
        p2_next.year_days = days_prod[eaad_pkg::DAY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
            year1_reg <= year1_next;
        if (en2 && v1_reg)
            p2_reg <= p2_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = p2_reg;

endmodule

/* hdl/eaad_cycle.sv */
// eaad_cycle: stages three and four, golden number, leap-day sum, epoch base
// day, corrected epact and the week quotient
// depends on eaad_pkg
module eaad_cycle
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  eaad_pkg::prep_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output eaad_pkg::cyc_t   out_data
);

    logic                           v3_reg;
    logic                           v4_reg;
    logic [eaad_pkg::GOLD_W-1:0]    gold3_reg;
    logic [eaad_pkg::GOLD_W-1:0]    gold3_next;
    logic [eaad_pkg::EPACT_W-1:0]   cterm3_reg;
    logic [eaad_pkg::EPACT_W-1:0]   cterm3_next;
    logic [eaad_pkg::SUM_W-1:0]     wsum3_reg;
    logic [eaad_pkg::SUM_W-1:0]     wsum3_next;
    logic [eaad_pkg::DAY_W-1:0]     base3_reg;
    logic [eaad_pkg::DAY_W-1:0]     base3_next;
    eaad_pkg::cyc_t                 p4_reg;
    eaad_pkg::cyc_t                 p4_next;
    logic                           en3;
    logic                           en4;
    logic [eaad_pkg::LEAP_W-1:0]    leap;
    logic [11:0]                    third_prod;
    logic [eaad_pkg::CENT_W-1:0]    cent_third;
    logic [eaad_pkg::FULL_W-1:0]    gold_mul;
    logic [eaad_pkg::CENT_W:0]      epact_sum;
    logic [eaad_pkg::EPACT_W-1:0]   epact_raw;
    logic [26:0]                    week_prod;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign in_ready = en3;

    // stage three
    always_comb
    begin
        gold_mul   = eaad_pkg::FULL_W'(in_data.gold_quot) * 12'd19;
        gold3_next = eaad_pkg::GOLD_W'(in_data.year - gold_mul);
        // y/4 - c + c/4
        leap = eaad_pkg::LEAP_W'(in_data.year >> 2) - eaad_pkg::LEAP_W'(in_data.century)
             + eaad_pkg::LEAP_W'(in_data.century >> 2);
        wsum3_next = eaad_pkg::SUM_W'(in_data.year) + eaad_pkg::SUM_W'(leap) + 13'd2;
        base3_next = in_data.year_days + eaad_pkg::DAY_W'(leap) + eaad_pkg::EPOCH_ADJ;
        third_prod = 12'(in_data.century) * 12'(eaad_pkg::THIRD_RECIP);
        cent_third = eaad_pkg::CENT_W'(third_prod >> eaad_pkg::THIRD_SHIFT);
        cterm3_next = eaad_pkg::EPACT_W'(in_data.century - (in_data.century >> 2)
                                         - cent_third);
    end

    // stage four
    always_comb
    begin
        epact_sum = 7'(cterm3_reg) + 7'(eaad_pkg::gold_term(gold3_reg));
        if (epact_sum >= 7'd30)
            epact_raw = eaad_pkg::EPACT_W'(epact_sum - 7'd30);
        else
            epact_raw = eaad_pkg::EPACT_W'(epact_sum);
        if (epact_raw == 5'd29)
            p4_next.epact = 5'd28;
        else if (epact_raw == 5'd28 && gold3_reg > 5'd10)
            p4_next.epact = 5'd27;
        else
            p4_next.epact = epact_raw;
        week_prod         = 27'(wsum3_reg) * 27'(eaad_pkg::WEEK_RECIP);
        p4_next.week_quot = eaad_pkg::Q7_W'(week_prod >> eaad_pkg::WEEK_SHIFT);
        p4_next.week_sum  = wsum3_reg;
        p4_next.base_day  = base3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en3)
                v3_reg <= in_valid;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && in_valid)
        begin
            gold3_reg  <= gold3_next;
            cterm3_reg <= cterm3_next;
            wsum3_reg  <= wsum3_next;
            base3_reg  <= base3_next;
        end
        if (en4 && v3_reg)
            p4_reg <= p4_next;
    end

    assign out_valid = v4_reg;
    assign out_data  = p4_reg;

endmodule

/* hdl/eaad_date.sv */
// eaad_date: last stage, weekday remainders, easter month, day and day number,
// advent day number, held in the output register
// depends on eaad_pkg
module eaad_date
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  eaad_pkg::cyc_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output eaad_pkg::date_t  out_data
);

    logic                           v5_reg;
    eaad_pkg::date_t                p5_reg;
    eaad_pkg::date_t                p5_next;
    logic                           en5;
    logic [eaad_pkg::SUM_W-1:0]     week_mul;
    logic [2:0]                     year_rem;
    logic [10:0]                    sev_prod;
    logic [eaad_pkg::EPACT_W-1:0]   sev_quot;
    logic [2:0]                     epact_rem;
    logic [3:0]                     j_sum;
    logic [2:0]                     j_val;
    logic signed [6:0]              l_val;
    logic [6:0]                     doy;
    logic [2:0]                     back_days;
    logic                           in_april;

    assign en5      = !v5_reg || out_ready;
    assign in_ready = en5;

    always_comb
    begin
        week_mul  = eaad_pkg::SUM_W'(in_data.week_quot) * 13'd7;
        year_rem  = 3'(in_data.week_sum - week_mul);
        sev_prod  = 11'(in_data.epact) * 11'(eaad_pkg::SEVENTH_RECIP);
        sev_quot  = eaad_pkg::EPACT_W'(sev_prod >> eaad_pkg::SEVENTH_SHIFT);
        epact_rem = 3'(in_data.epact - sev_quot * 5'd7);
        j_sum     = 4'(year_rem) + 4'(epact_rem);
        if (j_sum >= 4'd7)
            j_val = 3'(j_sum - 4'd7);
        else
            j_val = 3'(j_sum);
        l_val    = $signed({2'b00, in_data.epact}) - $signed({4'b0000, j_val});
        in_april = (l_val >= 7'sd4);
        doy      = $unsigned(l_val) + eaad_pkg::MARCH_DOY;
        // christmas weekday is year_rem - 1 mod 7, sunday steps back a full week
        case (year_rem)
            3'd0:    back_days = 3'd6;
            3'd1:    back_days = 3'd7;
            default: back_days = 3'(year_rem - 3'd1);
        endcase
        if (in_april)
        begin
            p5_next.easter_month = eaad_pkg::MONTH_APRIL;
            p5_next.easter_day   = eaad_pkg::MDAY_W'(l_val - 7'sd3);
        end
        else
        begin
            p5_next.easter_month = eaad_pkg::MONTH_MARCH;
            p5_next.easter_day   = eaad_pkg::MDAY_W'(l_val + 7'sd28);
        end
        p5_next.easter_day_number = in_data.base_day + eaad_pkg::DAY_W'(doy);
        p5_next.advent_day_number = in_data.base_day + eaad_pkg::ADVENT_OFS
                                  - eaad_pkg::DAY_W'(back_days);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en5)
            v5_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en5 && in_valid)
            p5_reg <= p5_next;
    end

    assign out_valid = v5_reg;
    assign out_data  = p5_reg;

endmodule
